@@ rtl/core/mllm_pkg.sv @@
// mllm_pkg: shared constants and types for the multi-literal line matcher
// used by mllm_cell and multi_literal_line_matcher
package mllm_pkg;

  localparam int unsigned NumPatternsDef   = 8;
  localparam int unsigned MaxPatternLenDef = 32;

  typedef enum logic [2:0] {
    CmdText    = 3'd0,
    CmdEol     = 3'd1,
    CmdPatByte = 3'd2,
    CmdPatLen  = 3'd3,
    CmdNewFile = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    RegIgnoreCase = 3'd0,
    RegWordMode   = 3'd1,
    RegLineMode   = 3'd2,
    RegInvert     = 3'd3,
    RegInUse      = 3'd4
  } reg_e;

  // per-cycle control handed to every cell
  typedef struct packed {
    logic       text;
    logic       clear;
    logic       start;
    logic       is_word;
    logic       line_mode;
    logic       word_mode;
    logic       ignore_case;
    logic [7:0] fbyte;
  } cell_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'h41 && c <= 8'h5a) return c + 8'd32;
    return c;
  endfunction

  function automatic logic word_byte(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
  endfunction

endpackage

@@ rtl/core/mllm_cell.sv @@
// mllm_cell: one pattern slot with its shift-and prefix vector
// depends on mllm_pkg; hands its hit flag down the chain each cycle
module mllm_cell import mllm_pkg::*; #(
  parameter int unsigned MaxPatternLen = MaxPatternLenDef,
  localparam int unsigned PosW = (MaxPatternLen > 1) ? $clog2(MaxPatternLen) : 1,
  localparam int unsigned LenW = $clog2(MaxPatternLen + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic            use_i,
  input  logic            wr_byte_i,
  input  logic [PosW-1:0] wr_pos_i,
  input  logic [7:0]      wr_data_i,
  input  logic            wr_len_i,
  input  logic [LenW-1:0] wr_len_val_i,
  input  logic            hit_i,
  output logic            hit_o,
  output logic            eol_hit_o
);

  logic [7:0]               pat_q [MaxPatternLen];
  logic [LenW-1:0]          len_q;
  logic [MaxPatternLen:1]   pre_q, pre_d;
  logic                     pend_q, pend_d;
  logic                     hit_now;
  logic                     end_bit;

  assign end_bit = (len_q != '0) && pre_q[len_q];

  always_comb begin
    pre_d   = pre_q;
    pend_d  = pend_q;
    hit_now = 1'b0;
    if (ctl_i.clear) begin
      pre_d  = '0;
      pend_d = 1'b0;
    end else if (ctl_i.text) begin
      if (use_i && !ctl_i.line_mode && ctl_i.word_mode && pend_q && !ctl_i.is_word)
        hit_now = 1'b1;
      for (int k = 1; k <= MaxPatternLen; k++) begin
        pre_d[k] = (k <= int'(len_q)) && (fold(pat_q[k-1], ctl_i.ignore_case) == ctl_i.fbyte)
                   && ((k == 1) ? ctl_i.start : pre_q[(k > 1) ? k - 1 : 1]);
      end
      pend_d = 1'b0;
      if (len_q != '0 && pre_d[len_q] && use_i && !ctl_i.line_mode) begin
        if (ctl_i.word_mode) pend_d = 1'b1;
        else hit_now = 1'b1;
      end
    end
  end

  assign hit_o = hit_i | hit_now;

  always_comb begin
    eol_hit_o = 1'b0;
    if (use_i) begin
      if (ctl_i.line_mode) eol_hit_o = (len_q == '0) ? ctl_i.start : end_bit;
      else if (ctl_i.word_mode) eol_hit_o = pend_q;
      else eol_hit_o = (len_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q  <= '0;
      pend_q <= 1'b0;
      len_q  <= '0;
      for (int i = 0; i < MaxPatternLen; i++) pat_q[i] <= '0;
    end else begin
      pre_q  <= pre_d;
      pend_q <= pend_d;
      if (wr_len_i) len_q <= wr_len_val_i;
      if (wr_byte_i) pat_q[wr_pos_i] <= wr_data_i;
    end
  end

endmodule

@@ rtl/core/multi_literal_line_matcher.sv @@
// multi_literal_line_matcher: top level, chain of pattern cells plus line control
// depends on mllm_pkg and mllm_cell
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i/in_stall_o  | command, text byte, pattern write
//  out     | output    | out_valid_o/out_stall_i| line_matched, line_number, sel_count
//  cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// one beat per cycle while the input is not stalled: every cell compares its
// whole pattern against the byte in the same cycle, the hit flag rides the
// cell chain into found_q; end of line gives the result from an output register;
// a one-entry skid register takes one more result while the output is stalled,
// and the input stalls only while that skid register is full.
// reset clears patterns, lengths, line state and counters; no clearing pass.
module multi_literal_line_matcher import mllm_pkg::*; #(
  parameter int unsigned NumPatterns   = NumPatternsDef,
  parameter int unsigned MaxPatternLen = MaxPatternLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  text_byte_i,
  input  logic [2:0]  pattern_index_i,
  input  logic [4:0]  pattern_position_i,
  input  logic [7:0]  pattern_byte_i,
  input  logic [5:0]  pattern_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        line_matched_o,
  output logic [31:0] line_number_o,
  output logic [31:0] sel_count_o
);

  localparam int unsigned PosW = (MaxPatternLen > 1) ? $clog2(MaxPatternLen) : 1;
  localparam int unsigned LenW = $clog2(MaxPatternLen + 1);
  localparam int unsigned CntW = $clog2(NumPatterns + 1);

  logic       ic_q, wm_q, lm_q, inv_q;
  logic [3:0] inuse_q;
  logic       prev_word_q, line_start_q, found_q;
  logic [31:0] line_cnt_q, hit_cnt_q;

  // output register plus skid
  logic        ov_q, sv_q;
  logic        om_q, sm_q;
  logic [31:0] on_q, oc_q, sn_q, sc_q;

  logic        acc;
  cmd_e        cmd;
  cell_ctl_t   ctl;
  logic [NumPatterns:0] chain;
  logic [NumPatterns-1:0] eol_hit;
  logic [CntW-1:0] act;
  logic        sel;
  logic [31:0] ln_next, hc_next;

  assign in_stall_o = sv_q;
  assign acc = in_valid_i && !in_stall_o;
  assign cmd = cmd_e'(command_i);

  assign act = (32'(inuse_q) > NumPatterns) ? CntW'(NumPatterns) : CntW'(inuse_q);

  always_comb begin
    ctl.text        = acc && cmd == CmdText;
    ctl.clear       = acc && (cmd == CmdEol || cmd == CmdNewFile);
    ctl.start       = lm_q ? line_start_q : (wm_q ? (line_start_q || !prev_word_q) : 1'b1);
    ctl.is_word     = word_byte(text_byte_i);
    ctl.line_mode   = lm_q;
    ctl.word_mode   = wm_q;
    ctl.ignore_case = ic_q;
    ctl.fbyte       = fold(text_byte_i, ic_q);
  end

  assign chain[0] = found_q;

  for (genvar p = 0; p < NumPatterns; p++) begin : g_cell
    logic use_p;
    assign use_p = CntW'(p) < act;
    // ctl.start carries line_start alone only in line mode; eol needs the raw flag
    cell_ctl_t cc;
    always_comb begin
      cc = ctl;
      if (!ctl.text) cc.start = line_start_q;
    end
    mllm_cell #(.MaxPatternLen(MaxPatternLen)) u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i       (cc),
      .use_i       (use_p),
      .wr_byte_i   (acc && cmd == CmdPatByte && 32'(pattern_index_i) == p &&
                    32'(pattern_position_i) < MaxPatternLen),
      .wr_pos_i    (PosW'(pattern_position_i)),
      .wr_data_i   (pattern_byte_i),
      .wr_len_i    (acc && cmd == CmdPatLen && 32'(pattern_index_i) == p),
      .wr_len_val_i((32'(pattern_length_i) > MaxPatternLen) ? LenW'(MaxPatternLen)
                                                           : LenW'(pattern_length_i)),
      .hit_i       (chain[p]),
      .hit_o       (chain[p+1]),
      .eol_hit_o   (eol_hit[p])
    );
  end

  assign sel     = (found_q || (|eol_hit)) != inv_q;
  assign ln_next = (line_cnt_q != '1) ? line_cnt_q + 32'd1 : line_cnt_q;
  assign hc_next = (sel && hit_cnt_q != '1) ? hit_cnt_q + 32'd1 : hit_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= 1'b0; wm_q <= 1'b0; lm_q <= 1'b0; inv_q <= 1'b0; inuse_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        RegIgnoreCase: ic_q    <= cfg_data_i[0];
        RegWordMode:   wm_q    <= cfg_data_i[0];
        RegLineMode:   lm_q    <= cfg_data_i[0];
        RegInvert:     inv_q   <= cfg_data_i[0];
        RegInUse:      inuse_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_word_q  <= 1'b0;
      line_start_q <= 1'b1;
      found_q      <= 1'b0;
      line_cnt_q   <= '0;
      hit_cnt_q    <= '0;
    end else if (acc) begin
      case (cmd)
        CmdText: begin
          prev_word_q  <= ctl.is_word;
          line_start_q <= 1'b0;
          found_q      <= chain[NumPatterns];
        end
        CmdEol: begin
          line_cnt_q   <= ln_next;
          hit_cnt_q    <= hc_next;
          prev_word_q  <= 1'b0;
          line_start_q <= 1'b1;
          found_q      <= 1'b0;
        end
        CmdNewFile: begin
          line_cnt_q   <= '0;
          hit_cnt_q    <= '0;
          prev_word_q  <= 1'b0;
          line_start_q <= 1'b1;
          found_q      <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // result beat goes to output register, or to skid when the full output register is stalled
  logic push;
  assign push = acc && cmd == CmdEol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || !out_stall_i) begin
        ov_q <= sv_q || push;
        sv_q <= 1'b0;
      end else if (push) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || !out_stall_i) begin
      if (sv_q) begin
        om_q <= sm_q; on_q <= sn_q; oc_q <= sc_q;
      end else begin
        om_q <= sel; on_q <= ln_next; oc_q <= hc_next;
      end
    end else if (push) begin
      sm_q <= sel; sn_q <= ln_next; sc_q <= hc_next;
    end
  end

  assign out_valid_o    = ov_q;
  assign line_matched_o = om_q;
  assign line_number_o  = on_q;
  assign sel_count_o    = oc_q;

endmodule

@@ verif/mllm_line_checker.sv @@
// mllm_line_checker: watches the input and result channels of the line matcher,
// predicts each end-of-line verdict and compares it; depends on mllm_pkg
module mllm_line_checker import mllm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  command_i,
  input  logic [7:0]  text_byte_i,
  input  logic [2:0]  pattern_index_i,
  input  logic [4:0]  pattern_position_i,
  input  logic [7:0]  pattern_byte_i,
  input  logic [5:0]  pattern_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        line_matched_i,
  input  logic [31:0] line_number_i,
  input  logic [31:0] sel_count_i,
  output int          fail_count_o,
  output int          pending_lines_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NP = NumPatternsDef;
  localparam int ML = MaxPatternLenDef;

  typedef struct packed {
    logic        matched;
    logic [31:0] number;
    logic [31:0] count;
  } line_verdict_t;

  logic       ign_case, word_md, line_md, invert;
  logic [3:0] in_use;
  logic [7:0] pat_mem [NP][ML];
  int         pat_len [NP];
  logic [ML:0] prefix [NP];
  logic [NP-1:0] word_end_pending;
  logic prev_word, line_start, found_in_line;
  logic [31:0] line_cnt, hit_cnt;
  line_verdict_t verdict_q[$];

  function automatic logic [7:0] lower(input logic [7:0] c);
    if (ign_case && c >= "A" && c <= "Z") return c + 8'd32;
    return c;
  endfunction

  function automatic logic is_wordish(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic int active_slots();
    return (in_use > NP) ? NP : int'(in_use);
  endfunction

  task automatic reset_line();
    for (int p = 0; p < NP; p++) prefix[p] = '0;
    word_end_pending = '0;
    prev_word = 1'b0;
    line_start = 1'b1;
    found_in_line = 1'b0;
  endtask

  task automatic feed_byte(input logic [7:0] c);
    int act;
    logic [7:0] fc;
    logic isw, st, eq, prv;
    act = active_slots();
    fc = lower(c);
    isw = is_wordish(c);
    if (line_md) st = line_start;
    else if (word_md) st = line_start || !prev_word;
    else st = 1'b1;
    for (int p = 0; p < NP; p++) begin
      if (p < act && !line_md && word_md && word_end_pending[p] && !isw)
        found_in_line = 1'b1;
      for (int k = ML; k >= 1; k--) begin
        eq = (k <= pat_len[p]) && (lower(pat_mem[p][k-1]) == fc);
        prv = (k == 1) ? st : prefix[p][k-1];
        prefix[p][k] = eq && prv;
      end
      word_end_pending[p] = 1'b0;
      if (pat_len[p] >= 1 && prefix[p][pat_len[p]] && p < act && !line_md) begin
        if (word_md) word_end_pending[p] = 1'b1;
        else found_in_line = 1'b1;
      end
    end
    prev_word = isw;
    line_start = 1'b0;
  endtask

  task automatic close_line();
    logic f;
    line_verdict_t v;
    f = found_in_line;
    for (int p = 0; p < active_slots(); p++) begin
      if (line_md) begin
        if (pat_len[p] == 0 ? line_start : prefix[p][pat_len[p]]) f = 1'b1;
      end else if (word_md) begin
        if (word_end_pending[p]) f = 1'b1;
      end else if (pat_len[p] == 0) begin
        f = 1'b1;
      end
    end
    f = f ^ invert;
    if (line_cnt != '1) line_cnt++;
    if (f && hit_cnt != '1) hit_cnt++;
    v.matched = f;
    v.number = line_cnt;
    v.count = hit_cnt;
    verdict_q.push_back(v);
    reset_line();
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    line_verdict_t exp_v;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      ign_case <= 0; word_md <= 0; line_md <= 0; invert <= 0; in_use <= 4'd1;
      for (int p = 0; p < NP; p++) begin
        pat_len[p] = 0;
        for (int k = 0; k < ML; k++) pat_mem[p][k] = '0;
      end
      reset_line();
      line_cnt = '0;
      hit_cnt = '0;
      verdict_q.delete();
      fail_count_o <= 0;
    end else begin
      // result side first: a verdict is never produced in the cycle its eol is taken
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with no line pending");
          errs++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (line_matched_i !== exp_v.matched) begin
            $error("line_matched expected %0d got %0d", exp_v.matched, line_matched_i);
            errs++;
          end
          if (line_number_i !== exp_v.number) begin
            $error("line_number expected %0d got %0d", exp_v.number, line_number_i);
            errs++;
          end
          if (sel_count_i !== exp_v.count) begin
            $error("sel_count expected %0d got %0d", exp_v.count, sel_count_i);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (in_valid_i && !in_stall_i) begin
        case (command_i)
          CmdText: feed_byte(text_byte_i);
          CmdEol: close_line();
          CmdPatByte: pat_mem[pattern_index_i][pattern_position_i] = pattern_byte_i;
          CmdPatLen: pat_len[pattern_index_i] =
              (pattern_length_i > ML) ? ML : int'(pattern_length_i);
          CmdNewFile: begin
            line_cnt = '0;
            hit_cnt = '0;
            reset_line();
          end
          default: ;
        endcase
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegIgnoreCase: ign_case <= cfg_data_i[0];
          RegWordMode: word_md <= cfg_data_i[0];
          RegLineMode: line_md <= cfg_data_i[0];
          RegInvert: invert <= cfg_data_i[0];
          RegInUse: in_use <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign pending_lines_o = verdict_q.size();
endmodule

@@ verif/tb_multi_literal_line_matcher.sv @@
// tb_multi_literal_line_matcher: stimulus and verdict for the line matcher
// depends on mllm_pkg, multi_literal_line_matcher and mllm_line_checker
module tb_multi_literal_line_matcher;
  import mllm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [3:0]  cfg_data_i = '0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [7:0]  text_byte_i = '0;
  logic [2:0]  pattern_index_i = '0;
  logic [4:0]  pattern_position_i = '0;
  logic [7:0]  pattern_byte_i = 8'd1;
  logic [5:0]  pattern_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        line_matched_o;
  logic [31:0] line_number_o, sel_count_o;
  int          fail_count, pending_lines;
  int          cycle_cnt = 0;
  int          stall_hold = 0;
  logic        stall_bursty = 0;

  // words the random lines are built from, so patterns actually hit
  logic [7:0] vocab [8][6];
  int         vocab_len [8];

  multi_literal_line_matcher i_dut (.*);

  mllm_line_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .command_i, .text_byte_i,
    .pattern_index_i, .pattern_position_i, .pattern_byte_i, .pattern_length_i,
    .out_valid_i(out_valid_o), .out_stall_i, .line_matched_i(line_matched_o),
    .line_number_i(line_number_o), .sel_count_i(sel_count_o),
    .fail_count_o(fail_count), .pending_lines_o(pending_lines)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("multi_literal_line_matcher: mismatch");
      $finish;
    end
  end

  // receiver stalls: mostly short, sometimes long, some calm stretches
  always @(posedge clk_i) begin
    if (cycle_cnt % 3000 == 0) stall_bursty <= $urandom_range(0, 2) != 0;
    if (stall_hold != 0) begin
      out_stall_i <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (!stall_bursty) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 199) == 0) begin
      out_stall_i <= 1'b1;
      stall_hold <= int'($urandom_range(10, 60));
    end else out_stall_i <= $urandom_range(0, 3) == 0;
  end

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 255));
      1: return 8'("A" + $urandom_range(0, 5));
      2: return " ";
      3: return "_";
      default: return 8'("a" + $urandom_range(0, 5));
    endcase
  endfunction

  task automatic send(input cmd_e c, input logic [7:0] tb = 0, input logic [2:0] idx = 0,
                      input logic [4:0] pos = 0, input logic [7:0] pb = 1,
                      input logic [5:0] len = 0);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 19) == 0) ?
          $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= c;
    text_byte_i <= tb;
    pattern_index_i <= idx;
    pattern_position_i <= pos;
    pattern_byte_i <= pb;
    pattern_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_lines != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(input reg_e r, input logic [3:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(posedge clk_i);
  endtask

  task automatic load_pattern(input int slot, input int word);
    for (int k = 0; k < vocab_len[word]; k++)
      send(CmdPatByte, 0, 3'(slot), 5'(k), vocab[word][k]);
    send(CmdPatLen, 0, 3'(slot), 0, 1, 6'(vocab_len[word]));
  endtask

  task automatic random_line();
    int n;
    n = $urandom_range(0, 4);
    for (int w = 0; w < n; w++) begin
      if ($urandom_range(0, 2) != 0) begin
        int v;
        v = $urandom_range(0, 7);
        for (int k = 0; k < vocab_len[v]; k++)
          send(CmdText, ($urandom_range(0, 3) == 0 && vocab[v][k] >= "a" &&
               vocab[v][k] <= "z") ? vocab[v][k] - 8'd32 : vocab[v][k]);
      end else send(CmdText, random_byte());
      if ($urandom_range(0, 1)) send(CmdText, ($urandom_range(0, 1)) ? " " : random_byte());
    end
    send(CmdEol);
  endtask

  initial begin
    int items;
    for (int v = 0; v < 8; v++) begin
      vocab_len[v] = $urandom_range(1, 5);
      for (int k = 0; k < 6; k++) vocab[v][k] = 8'("a" + $urandom_range(0, 5));
    end
    vocab[0][0] = "_";
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pattern, full-length pattern, byte extremes, ignored commands
    send(CmdEol);
    send(CmdText, 8'h00);
    send(CmdText, 8'hff);
    send(CmdEol);
    for (int k = 0; k < 32; k += 31)
      send(CmdPatByte, 0, 3'd7, 5'(k), (k == 0) ? 8'hff : 8'h01);
    send(CmdPatLen, 0, 7, 0, 1, 6'd63);
    send(CmdPatByte, 0, 1, 5'd31, 8'h00);
    send(CmdPatLen, 0, 1, 0, 1, 6'd32);
    send(cmd_e'(3'd5));
    send(cmd_e'(3'd7), 8'h55, 3'd5, 5'd10, 8'haa, 6'd21);
    send(CmdPatByte, 0, 0, 0, "a");
    send(CmdPatLen, 0, 0, 0, 1, 6'd1);
    send(CmdText, "A");
    send(CmdEol);
    send(CmdNewFile);
    send(CmdText, "a");
    send(CmdEol);
    drain();

    // sweep settings, extremes first; each sweep may reload some patterns
    for (int phase = 0; phase < 16; phase++) begin
      logic [3:0] use_n;
      use_n = (phase == 0) ? 4'd0 : (phase == 1) ? 4'd15 : (phase == 2) ? 4'd8 :
              4'($urandom_range(0, 9));
      write_reg(RegIgnoreCase, phase[0]);
      write_reg(RegWordMode, phase[1]);
      write_reg(RegLineMode, phase[2] && phase[3]);
      write_reg(RegInvert, phase[3]);
      write_reg(RegInUse, use_n);
      cfg_we_i <= 1'b0;
      for (int s = 0; s < 8; s++)
        if ($urandom_range(0, 2) == 0) load_pattern(s, $urandom_range(0, 7));
      if ($urandom_range(0, 4) == 0)
        send(CmdPatLen, 0, 3'($urandom_range(0, 7)), 0, 1, 6'd0);
      items = 0;
      while (items < 12) begin
        if ($urandom_range(0, 19) == 0) send(CmdNewFile);
        random_line();
        items++;
      end
      // sender waits until every verdict has come back
      drain();
    end
    drain();
    if (fail_count == 0) $display("multi_literal_line_matcher: match");
    else $display("multi_literal_line_matcher: mismatch");
    $finish;
  end
endmodule
